/* hw/rtl/bole_pkg.sv */
// Shared types and codes for the bounded ordered list engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package bole_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned COUNT_W = 5;

  // Request codes carried in the input tuser
  typedef enum logic [1:0] {
    REQ_INS_POS  = 2'd0,
    REQ_INS_SORT = 2'd1,
    REQ_REM_POS  = 2'd2,
    REQ_REM_VAL  = 2'd3
  } req_t;

  // Status codes carried in the output tuser
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // One finished result handed from the sequencer to the output register
  typedef struct packed {
    status_t                    status;
    logic signed [DATA_W-1:0]   removed_value;
    logic        [COUNT_W-1:0]  entry_count;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/bounded_ordered_list_engine.sv */
// Bounded ordered list engine: keeps a head-first list of up to CAPACITY
// signed 32-bit values and serves one request at a time.
// Channels: slave side s_tvalid/s_tready with s_tuser = request code and
// s_tdata = value and position; master side m_tvalid/m_tready with
// m_tuser = status and m_tdata = removed value and entry count.
// A transaction takes one step per list entry it touches, through the RAM's
// read and write ports and the shared comparator. With n the entry count,
// insert at position p clips p to n and remove at position p clips p to
// n-1; requests on a full or empty list finish without touching it.
// One request is in flight at a time; s_tready is high only while the
// sequencer is idle.
// Reset clears the count; entry contents need no clearing.
// The result sits in an output register; the next transaction is accepted
// while it waits, and the sequencer holds its following result until the
// register is taken.
`default_nettype none

module bounded_ordered_list_engine
  import bole_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] item_value, [36:32] position, [39:37] zero
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] entry_count, [39:37] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                     res_valid;
  logic                     res_ready;
  result_t                  res;
  result_t                  out_res;
  logic                     ram_wr_en;
  logic [AW-1:0]            ram_wr_addr;
  logic signed [DATA_W-1:0] ram_wr_data;
  logic [AW-1:0]            ram_rd_addr;
  logic signed [DATA_W-1:0] ram_rd_data;

  bole_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_req      (req_t'(s_tuser)),
    .in_val      (s_tdata[31:0]),
    .in_pos      (s_tdata[36:32]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  bole_list_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.entry_count, out_res.removed_value};
  assign m_tuser = out_res.status;

endmodule

`default_nettype wire

/* hw/rtl/bole_list_ram.sv */
// Entry store of the list: one write port, one read port, registered read data.
// Depends on bole_pkg for the data width.
`default_nettype none

module bole_list_ram
  import bole_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/bole_cmp_unit.sv */
// Shared signed comparator used by the sequencer for every scan step.
// Depends on bole_pkg for the data width.
`default_nettype none

module bole_cmp_unit
  import bole_pkg::*;
(
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     lt,
  output logic                     eq
);

  // Signed less-than and equality of a against b
  assign lt = (a < b);
  assign eq = (a == b);

endmodule

`default_nettype wire

/* hw/rtl/bole_ctrl.sv */
// Sequencer of the list engine: scans, shifts entries through the RAM port
// one step at a time and builds the result. Depends on bole_pkg, bole_cmp_unit.
`default_nettype none

module bole_ctrl
  import bole_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned AW       = 4,
  parameter int unsigned CW       = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  req_t                     in_req,
  input  logic signed [DATA_W-1:0] in_val,
  input  logic [POS_W-1:0]         in_pos,
  output logic                     res_valid,
  input  logic                     res_ready,
  output result_t                  res,
  output logic                     ram_wr_en,
  output logic [AW-1:0]            ram_wr_addr,
  output logic signed [DATA_W-1:0] ram_wr_data,
  output logic [AW-1:0]            ram_rd_addr,
  input  logic signed [DATA_W-1:0] ram_rd_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_TAKE,
    S_TAKE_WAIT,
    S_UP,
    S_UP_WR,
    S_DN,
    S_DN_WR,
    S_DONE
  } state_t;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  state_t                   state;
  req_t                     req;
  logic signed [DATA_W-1:0] val;
  logic [CW-1:0]            count;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            tgt;
  status_t                  status;
  logic signed [DATA_W-1:0] removed;
  logic                     cmp_lt;
  logic                     cmp_eq;
  logic [CW-1:0]            idx_dec;
  logic [CW-1:0]            idx_inc;

  assign idx_dec = idx - ONE_C;
  assign idx_inc = idx + ONE_C;

  // Shared comparator: stored entry against request value
  bole_cmp_unit u_cmp (
    .a  (ram_rd_data),
    .b  (val),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.status        = status;
  assign res.removed_value = removed;
  assign res.entry_count   = COUNT_W'(count);

  // RAM port steering
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx[AW-1:0];
    ram_wr_data = ram_rd_data;
    ram_rd_addr = idx[AW-1:0];
    unique case (state)
      S_TAKE:  ram_rd_addr = tgt[AW-1:0];
      S_UP: begin
        ram_rd_addr = idx_dec[AW-1:0];
        if (idx == tgt) begin
          ram_wr_en   = 1'b1;
          ram_wr_data = val;
        end
      end
      S_UP_WR: ram_wr_en = 1'b1;
      S_DN:    ram_rd_addr = idx_inc[AW-1:0];
      S_DN_WR: ram_wr_en = 1'b1;
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      idx     <= '0;
      tgt     <= '0;
      req     <= REQ_INS_POS;
      val     <= '0;
      status  <= ST_OK;
      removed <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req     <= in_req;
            val     <= in_val;
            status  <= ST_OK;
            removed <= '0;
            idx     <= '0;
            unique case (in_req)
              REQ_INS_POS: begin
                if (count == CAP_C) begin
                  status <= ST_FULL;
                  state  <= S_DONE;
                end else begin
                  // clip to tail
                  tgt   <= (32'(in_pos) > 32'(count)) ? count : CW'(in_pos);
                  idx   <= count;
                  state <= S_UP;
                end
              end
              REQ_INS_SORT: begin
                if (count == CAP_C) begin
                  status <= ST_FULL;
                  state  <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              REQ_REM_POS: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_DONE;
                end else begin
                  // clip to last entry
                  tgt   <= (32'(in_pos) >= 32'(count)) ? (count - ONE_C) : CW'(in_pos);
                  state <= S_TAKE;
                end
              end
              REQ_REM_VAL: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end

        // Issue a read of the entry under the scan pointer, or end the scan
        S_SCAN: begin
          if (idx == count) begin
            if (req == REQ_INS_SORT) begin
              tgt   <= count;
              idx   <= count;
              state <= S_UP;
            end else begin
              status <= ST_NOTFOUND;
              state  <= S_DONE;
            end
          end else begin
            state <= S_SCAN_CHK;
          end
        end

        // Check the entry just read
        S_SCAN_CHK: begin
          if (req == REQ_INS_SORT) begin
            if (!cmp_lt) begin
              tgt   <= idx;
              idx   <= count;
              state <= S_UP;
            end else begin
              idx   <= idx_inc;
              state <= S_SCAN;
            end
          end else begin
            if (cmp_eq) begin
              removed <= ram_rd_data;
              state   <= S_DN;
            end else begin
              idx   <= idx_inc;
              state <= S_SCAN;
            end
          end
        end

        S_TAKE: state <= S_TAKE_WAIT;

        S_TAKE_WAIT: begin
          removed <= ram_rd_data;
          idx     <= tgt;
          state   <= S_DN;
        end

        // Shift toward the tail, then drop the value into its slot
        S_UP: begin
          if (idx == tgt) begin
            count <= count + ONE_C;
            state <= S_DONE;
          end else begin
            state <= S_UP_WR;
          end
        end

        S_UP_WR: begin
          idx   <= idx_dec;
          state <= S_UP;
        end

        // Shift toward the head over the removed slot
        S_DN: begin
          if (idx_inc == count) begin
            count <= count - ONE_C;
            state <= S_DONE;
          end else begin
            state <= S_DN_WR;
          end
        end

        S_DN_WR: begin
          idx   <= idx_inc;
          state <= S_DN;
        end

        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("list count above capacity");

  // An accepted transaction starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("accepted transaction did not start");

  // A handed-off result returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> state == S_IDLE)
    else $error("sequencer did not return to idle");

  // Writes land inside the list storage
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> idx < CAP_C)
    else $error("write outside the list storage");

  // Count changes only on completing a transaction
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_UP && state != S_DN) |=> $stable(count))
    else $error("count changed outside a completing step");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench for bounded_ordered_list_engine: drives list requests into the
// input stream and checks each result against an in-order list predictor.
// Depends on bole_pkg and the engine RTL only.
module tb;
  import bole_pkg::*;

  localparam int unsigned LIST_CAP     = 16;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [31:0] item_value, [36:32] position, [39:37] zero
  logic [1:0]  s_tuser = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] removed_value, [36:32] entry_count, [39:37] zero
  logic [1:0]  m_tuser;        // [1:0] status

  // Model of the list contents, head first
  logic signed [31:0] list_vals [LIST_CAP];
  int unsigned        list_len = 0;

  result_t     pending_results [$];
  result_t     oldest_result;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  logic        hold_request = 1'b0;
  bit          grow_mode = 1'b1;

  bounded_ordered_list_engine #(.CAPACITY(LIST_CAP)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Apply one request to the list model and return the result it should give
  function automatic result_t apply_list_request(req_t req, logic signed [31:0] val,
                                                 logic [4:0] pos);
    result_t     res;
    int unsigned slot;
    int unsigned idx;
    res.status        = ST_OK;
    res.removed_value = '0;
    slot              = 0;
    if (req == REQ_INS_POS || req == REQ_INS_SORT) begin
      if (list_len >= LIST_CAP) begin
        res.status = ST_FULL;
      end else begin
        if (req == REQ_INS_POS) begin
          slot = (pos > list_len) ? list_len : pos;
        end else begin
          while (slot < list_len && list_vals[slot] < val) slot++;
        end
        for (idx = list_len; idx > slot; idx--) list_vals[idx] = list_vals[idx-1];
        list_vals[slot] = val;
        list_len++;
      end
    end else if (list_len == 0) begin
      res.status = ST_EMPTY;
    end else begin
      if (req == REQ_REM_POS) begin
        slot = (pos >= list_len) ? list_len - 1 : pos;
      end else begin
        while (slot < list_len && list_vals[slot] != val) slot++;
      end
      if (slot == list_len) begin
        res.status = ST_NOTFOUND;
      end else begin
        res.removed_value = list_vals[slot];
        for (idx = slot; idx + 1 < list_len; idx++) list_vals[idx] = list_vals[idx+1];
        list_len--;
      end
    end
    res.entry_count = list_len[4:0];
    return res;
  endfunction

  // Offer one request after a random gap; record its expected result on acceptance
  task automatic send_request(req_t req, logic signed [31:0] val, logic [4:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = req;
    s_tdata  = {3'b000, pos, val};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_list_request(req, val, pos));
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_for_results();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed($urandom_range(16)) - 8;
      4: begin
        case ($urandom_range(3))
          0: return MAX_VAL;
          1: return MIN_VAL;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] pick_position();
    if ($urandom_range(4) == 0) return 5'($urandom_range(16));
    return (list_len > 16) ? 5'd16 : 5'($urandom_range(list_len));
  endfunction

  // Grow toward full, then shrink toward empty, lingering a little at each end
  task automatic send_random_request();
    req_t               req;
    logic signed [31:0] val;
    if (list_len == LIST_CAP && grow_mode && $urandom_range(2) == 0) grow_mode = 1'b0;
    if (list_len == 0 && !grow_mode && $urandom_range(2) == 0) grow_mode = 1'b1;
    if ($urandom_range(99) < (grow_mode ? 75 : 25))
      req = $urandom_range(1) ? REQ_INS_POS : REQ_INS_SORT;
    else
      req = $urandom_range(1) ? REQ_REM_POS : REQ_REM_VAL;
    val = pick_value();
    if (req == REQ_REM_VAL && list_len != 0 && $urandom_range(9) < 7)
      val = list_vals[$urandom_range(list_len - 1)];
    send_request(req, val, pick_position());
  endtask

  // Extremes, every request kind and the empty, append, clip and absent cases
  task automatic test_directed_cases();
    send_request(REQ_REM_POS,  32'sd0,   5'd0);
    send_request(REQ_REM_VAL,  32'sd0,   5'd0);
    send_request(REQ_INS_POS,  MAX_VAL,  5'd0);
    send_request(REQ_INS_POS,  MIN_VAL,  5'd16);
    send_request(REQ_INS_SORT, -32'sd1,  5'd31);
    send_request(REQ_INS_SORT, MAX_VAL,  5'd0);
    send_request(REQ_INS_POS,  32'sd5,   5'd2);
    send_request(REQ_INS_SORT, MIN_VAL,  5'd0);
    send_request(REQ_INS_SORT, 32'sd0,   5'd0);
    send_request(REQ_INS_POS,  -32'sd1,  5'd5);
    send_request(REQ_REM_VAL,  32'sd12345, 5'd0);
    send_request(REQ_REM_VAL,  MAX_VAL,  5'd0);
    send_request(REQ_REM_VAL,  -32'sd1,  5'd0);
    send_request(REQ_REM_POS,  32'sd0,   5'd16);
    send_request(REQ_REM_POS,  32'sd0,   5'd0);
    send_request(REQ_REM_POS,  32'sd0,   5'd1);
    send_request(REQ_REM_VAL,  MIN_VAL,  5'd0);
    send_request(REQ_REM_POS,  32'sd0,   5'd15);
    send_request(REQ_REM_POS,  32'sd0,   5'd0);
    send_request(REQ_REM_VAL,  MAX_VAL,  5'd0);
    wait_for_results();
  endtask

  // Fill to capacity, hit the full case, then drain to empty
  task automatic test_capacity_limits();
    while (list_len < LIST_CAP) send_request(REQ_INS_SORT, pick_value(), 5'd0);
    send_request(REQ_INS_POS,  pick_value(), 5'd0);
    send_request(REQ_INS_SORT, pick_value(), 5'd16);
    send_request(REQ_REM_VAL,  32'sd1000003, 5'd0);
    while (list_len > 0) send_request(REQ_REM_POS, pick_value(), pick_position());
    send_request(REQ_REM_VAL, pick_value(), 5'd0);
    wait_for_results();
  endtask

  // Hold off the result side for a long stretch while requests keep coming
  task automatic test_output_stall();
    int unsigned n;
    hold_request = 1'b1;
    for (n = 0; n < 12; n++) send_random_request();
    wait_for_results();
  endtask

  task automatic test_random_traffic(int unsigned items, int unsigned send_pct,
                                     int unsigned recv_pct);
    int unsigned n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (n = 0; n < items; n++) send_random_request();
    wait_for_results();
  endtask

  // Drive the result-side ready; a hold request holds it low, then clears the request
  initial begin : drive_ready
    int unsigned held;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready = 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_request = 1'b0;
      end
      m_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual status %0d value %0d count %0d",
                 $time, m_tuser, $signed(m_tdata[31:0]), m_tdata[36:32]);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_tuser != oldest_result.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, oldest_result.status, m_tuser);
          error_count++;
        end
        if (m_tdata[31:0] != oldest_result.removed_value) begin
          $display("%0t removed value mismatch: expected %0d actual %0d",
                   $time, oldest_result.removed_value, $signed(m_tdata[31:0]));
          error_count++;
        end
        if (m_tdata[36:32] != oldest_result.entry_count) begin
          $display("%0t entry count mismatch: expected %0d actual %0d",
                   $time, oldest_result.entry_count, m_tdata[36:32]);
          error_count++;
        end
      end
    end
  end

  // End the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 24;
    recv_idle_pct = 45;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_capacity_limits();
    test_random_traffic(560, 24, 45);
    test_output_stall();
    test_random_traffic(560, 45, 24);
    test_random_traffic(560, 0, 0);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bole_pkg.sv
hw/rtl/bole_list_ram.sv
hw/rtl/bole_cmp_unit.sv
hw/rtl/bole_ctrl.sv
hw/rtl/bounded_ordered_list_engine.sv
tb/tb.sv
